// ===== src/aqs_pkg.sv =====
`default_nettype none

package aqs_pkg;

   localparam int SEGMENTS = 7;

   localparam logic [2:0]  LAST_SEGMENT = 3'd6;
   localparam logic [3:0]  DECIMAL_BASE = 4'd10;
   localparam logic [8:0]  INDEX_TOP    = 9'd500;

   typedef struct packed {
      logic        pollutant;
      logic [12:0] concentration;
      logic        last;
   } req_type;

   typedef struct packed {
      logic [8:0] sub_index;
      logic [8:0] overall_index;
      logic       over_range;
      logic       group_done;
   } rsp_type;

   // Breakpoints in tenths of a microgram per cubic metre: [table][pollutant][segment].
   localparam logic [12:0] BP_LO [0:1][0:1][0:SEGMENTS-1] = '{
      '{ '{13'd0, 13'd550, 13'd1550, 13'd2550, 13'd3550, 13'd4250, 13'd5050},
         '{13'd0, 13'd121, 13'd355,  13'd555,  13'd1505, 13'd2505, 13'd3505} },
      '{ '{13'd0, 13'd510, 13'd1510, 13'd2510, 13'd3510, 13'd4210, 13'd5010},
         '{13'd0, 13'd360, 13'd760,  13'd1160, 13'd1510, 13'd2510, 13'd3510} }
   };

   localparam logic [12:0] BP_HI [0:1][0:1][0:SEGMENTS-1] = '{
      '{ '{13'd540, 13'd1540, 13'd2540, 13'd3540, 13'd4240, 13'd5040, 13'd6040},
         '{13'd120, 13'd354,  13'd554,  13'd1504, 13'd2504, 13'd3504, 13'd5004} },
      '{ '{13'd500, 13'd1500, 13'd2500, 13'd3500, 13'd4200, 13'd5000, 13'd6000},
         '{13'd350, 13'd750,  13'd1150, 13'd1500, 13'd2500, 13'd3500, 13'd5000} }
   };

   localparam logic [8:0] IDX_LO [0:SEGMENTS-1] = '{
      9'd0, 9'd51, 9'd101, 9'd151, 9'd201, 9'd301, 9'd401
   };

   localparam logic [8:0] IDX_HI [0:SEGMENTS-1] = '{
      9'd50, 9'd100, 9'd150, 9'd200, 9'd300, 9'd400, 9'd500
   };

endpackage

`default_nettype wire

// ===== src/aqs_mod10.sv =====
`default_nettype none

module aqs_mod10
   import aqs_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [12:0] value,
   output logic             done,
   output logic [3:0]       remainder
);

   logic [12:0] shift_ff, shift_in;
   logic [3:0]  rem_ff, rem_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic [4:0]  trial;

   // The remainder is built one bit at a time, most significant bit first.
   assign trial = {rem_ff, shift_ff[12]};

   always_comb begin
      shift_in = shift_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      run_in   = run_ff;
      done_in  = 1'b0;
      if (start) begin
         shift_in = value;
         rem_in   = 4'd0;
         cnt_in   = 4'd0;
         run_in   = 1'b1;
      end else if (run_ff) begin
         shift_in = {shift_ff[11:0], 1'b0};
         if (trial >= {1'b0, DECIMAL_BASE}) begin
            rem_in = 4'(trial - {1'b0, DECIMAL_BASE});
         end else begin
            rem_in = trial[3:0];
         end
         cnt_in = cnt_ff + 4'd1;
         if (cnt_ff == 4'd12) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 4'd0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

   property p_rem_final;
      @(posedge clock) disable iff (reset) done_ff |-> (rem_ff < DECIMAL_BASE);
   endproperty
   assert property (p_rem_final) else $error("Remainder by ten out of range.");

   property p_done_after_run;
      @(posedge clock) disable iff (reset) done_ff |-> $past(run_ff);
   endproperty
   assert property (p_done_after_run) else $error("Done without a running pass.");

   property p_rem_bound;
      @(posedge clock) disable iff (reset) run_ff |-> (rem_ff < DECIMAL_BASE);
   endproperty
   assert property (p_rem_bound) else $error("Partial remainder out of range.");

endmodule

`default_nettype wire

// ===== src/aqs_muldiv.sv =====
`default_nettype none

module aqs_muldiv
   import aqs_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [6:0]  multiplier,
   input  wire logic [10:0] multiplicand,
   input  wire logic [10:0] divisor,
   output logic             done,
   output logic [6:0]       quotient
);

   logic [17:0] acc_ff, acc_in;
   logic [17:0] mc_ff, mc_in;
   logic [6:0]  mp_ff, mp_in;
   logic [17:0] dsh_ff, dsh_in;
   logic [6:0]  q_ff, q_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic        phase_ff, phase_in;
   logic        run_ff, run_in;
   logic        done_ff, done_in;

   // Shift-and-add product over the multiplier bits, then one quotient bit per cycle.
   always_comb begin
      acc_in   = acc_ff;
      mc_in    = mc_ff;
      mp_in    = mp_ff;
      dsh_in   = dsh_ff;
      q_in     = q_ff;
      cnt_in   = cnt_ff;
      phase_in = phase_ff;
      run_in   = run_ff;
      done_in  = 1'b0;
      if (start) begin
         acc_in   = 18'd0;
         mc_in    = {7'd0, multiplicand};
         mp_in    = multiplier;
         dsh_in   = {1'b0, divisor, 6'd0};
         q_in     = 7'd0;
         cnt_in   = 3'd0;
         phase_in = 1'b0;
         run_in   = 1'b1;
      end else if (run_ff) begin
         cnt_in = cnt_ff + 3'd1;
         if (!phase_ff) begin
            if (mp_ff[0]) begin
               acc_in = acc_ff + mc_ff;
            end
            mc_in = {mc_ff[16:0], 1'b0};
            mp_in = {1'b0, mp_ff[6:1]};
            if (cnt_ff == 3'd6) begin
               phase_in = 1'b1;
               cnt_in   = 3'd0;
            end
         end else begin
            if (acc_ff >= dsh_ff) begin
               acc_in = acc_ff - dsh_ff;
               q_in   = {q_ff[5:0], 1'b1};
            end else begin
               q_in   = {q_ff[5:0], 1'b0};
            end
            dsh_in = {1'b0, dsh_ff[17:1]};
            if (cnt_ff == 3'd6) begin
               run_in  = 1'b0;
               done_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= 1'b0;
         done_ff  <= 1'b0;
         phase_ff <= 1'b0;
         cnt_ff   <= 3'd0;
      end else begin
         run_ff   <= run_in;
         done_ff  <= done_in;
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
      end
      acc_ff <= acc_in;
      mc_ff  <= mc_in;
      mp_ff  <= mp_in;
      dsh_ff <= dsh_in;
      q_ff   <= q_in;
   end

   assign done     = done_ff;
   assign quotient = q_ff;

   property p_start_runs;
      @(posedge clock) disable iff (reset) start |=> (run_ff && !phase_ff);
   endproperty
   assert property (p_start_runs) else $error("Start did not begin the multiply phase.");

   property p_done_from_divide;
      @(posedge clock) disable iff (reset) done_ff |-> $past(run_ff && phase_ff);
   endproperty
   assert property (p_done_from_divide) else $error("Quotient ready outside the divide phase.");

   property p_quotient_bound;
      @(posedge clock) disable iff (reset) done_ff |-> (q_ff <= 7'd100);
   endproperty
   assert property (p_quotient_bound) else $error("Quotient exceeds the index span.");

endmodule

`default_nettype wire

// ===== src/air_quality_subindex_unit.sv =====
// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_ready  req_data (aqs_pkg::req_type)
// rsp       out        rsp_valid / rsp_ready  rsp_data (aqs_pkg::rsp_type)
// csr       in         csr_we                 csr_wdata (table_select)
//
// A transaction runs the serial remainder by ten, the segment search, the serial multiply
// and divide, and then loads the result; a reading that falls in a gap between segments
// or over the range skips the divider and is loaded straight after the search.
// Reset is synchronous and clears the running maximum, the table select and all control.
// The next request is taken the cycle after a result is loaded, even while that result
// waits in the output register; the following result is held back until it is taken.

`default_nettype none

module air_quality_subindex_unit
   import aqs_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data,
   input  wire logic    csr_we,
   input  wire logic    csr_wdata
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_MOD    = 3'd1;
   localparam logic [2:0] S_SEARCH = 3'd2;
   localparam logic [2:0] S_MULDIV = 3'd3;
   localparam logic [2:0] S_FIN    = 3'd4;

   logic [2:0]  state_ff, state_in;
   logic        tab_ff, tab_in;
   req_type     req_ff, req_in;
   logic        tsel_ff, tsel_in;
   logic [12:0] v_ff, v_in;
   logic [2:0]  seg_ff, seg_in;
   logic [8:0]  sub_ff, sub_in;
   logic        over_ff, over_in;
   logic [8:0]  max_ff, max_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   logic        accept;
   logic        mod_done;
   logic [3:0]  remainder;
   logic        md_start;
   logic        md_done;
   logic [6:0]  quotient;
   logic [12:0] seg_lo, seg_hi;
   logic        hit, below;
   logic [2:0]  seg_prev;
   logic        load;
   logic [8:0]  overall;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   aqs_mod10 u_mod10 (
      .clock     (clock),
      .reset     (reset),
      .start     (accept),
      .value     (req_data.concentration),
      .done      (mod_done),
      .remainder (remainder)
   );

   assign seg_lo   = BP_LO[tsel_ff][req_ff.pollutant][seg_ff];
   assign seg_hi   = BP_HI[tsel_ff][req_ff.pollutant][seg_ff];
   assign hit      = (v_ff >= seg_lo) && (v_ff <= seg_hi);
   assign below    = (v_ff < seg_lo);
   assign seg_prev = (seg_ff == 3'd0) ? 3'd0 : seg_ff - 3'd1;
   assign md_start = (state_ff == S_SEARCH) && hit;

   aqs_muldiv u_muldiv (
      .clock        (clock),
      .reset        (reset),
      .start        (md_start),
      .multiplier   (7'(IDX_HI[seg_ff] - IDX_LO[seg_ff])),
      .multiplicand (11'(v_ff - seg_lo)),
      .divisor      (11'(seg_hi - seg_lo)),
      .done         (md_done),
      .quotient     (quotient)
   );

   assign load    = (state_ff == S_FIN) && (!rsp_valid_ff || rsp_ready);
   assign overall = (sub_ff > max_ff) ? sub_ff : max_ff;

   always_comb begin
      state_in     = state_ff;
      tab_in       = csr_we ? csr_wdata : tab_ff;
      req_in       = req_ff;
      tsel_in      = tsel_ff;
      v_in         = v_ff;
      seg_in       = seg_ff;
      sub_in       = sub_ff;
      over_in      = over_ff;
      max_in       = max_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               req_in   = req_data;
               tsel_in  = tab_ff;
               state_in = S_MOD;
            end
         end
         S_MOD: begin
            if (mod_done) begin
               v_in     = req_ff.pollutant ? req_ff.concentration
                                           : req_ff.concentration - {9'd0, remainder};
               seg_in   = 3'd0;
               over_in  = 1'b0;
               state_in = S_SEARCH;
            end
         end
         S_SEARCH: begin
            if (hit) begin
               state_in = S_MULDIV;
            end else if (below) begin
               sub_in   = IDX_HI[seg_prev];
               state_in = S_FIN;
            end else if (seg_ff == LAST_SEGMENT) begin
               sub_in   = INDEX_TOP;
               over_in  = 1'b1;
               state_in = S_FIN;
            end else begin
               seg_in = seg_ff + 3'd1;
            end
         end
         S_MULDIV: begin
            if (md_done) begin
               sub_in   = IDX_LO[seg_ff] + {2'd0, quotient};
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (load) begin
               rsp_in.sub_index     = sub_ff;
               rsp_in.overall_index = overall;
               rsp_in.over_range    = over_ff;
               rsp_in.group_done    = req_ff.last;
               rsp_valid_in         = 1'b1;
               max_in               = req_ff.last ? 9'd0 : overall;
               state_in             = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         tab_ff       <= 1'b0;
         max_ff       <= 9'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tab_ff       <= tab_in;
         max_ff       <= max_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff  <= req_in;
      tsel_ff <= tsel_in;
      v_ff    <= v_in;
      seg_ff  <= seg_in;
      sub_ff  <= sub_in;
      over_ff <= over_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   property p_overall_covers_sub;
      @(posedge clock) disable iff (reset)
         rsp_valid_ff |-> (rsp_ff.overall_index >= rsp_ff.sub_index);
   endproperty
   assert property (p_overall_covers_sub) else $error("Overall index below sub index.");

   property p_over_range_saturates;
      @(posedge clock) disable iff (reset)
         (rsp_valid_ff && rsp_ff.over_range) |-> (rsp_ff.sub_index == INDEX_TOP);
   endproperty
   assert property (p_over_range_saturates) else $error("Over-range result not saturated.");

   property p_group_clears_max;
      @(posedge clock) disable iff (reset)
         (load && req_ff.last) |=> (max_ff == 9'd0);
   endproperty
   assert property (p_group_clears_max) else $error("Running maximum kept past group end.");

   property p_sub_bound;
      @(posedge clock) disable iff (reset)
         rsp_valid_ff |-> (rsp_ff.overall_index <= INDEX_TOP);
   endproperty
   assert property (p_sub_bound) else $error("Index above the table top.");

endmodule

`default_nettype wire

// ===== tb/air_quality_subindex_unit_tb.sv =====
`timescale 1ns / 1ps

module air_quality_subindex_unit_tb;
   import aqs_pkg::*;

   localparam logic PM10      = 1'b0;
   localparam logic PM25      = 1'b1;
   localparam logic TABLE_EPA = 1'b0;
   localparam logic TABLE_MEP = 1'b1;

   localparam int SETTLE_CYCLES  = 40;
   localparam int QUIET_LIMIT    = 1000;
   localparam int RANDOM_PHASES  = 4;
   localparam int PHASE_READINGS = 475;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b1;
   rsp_type rsp_data;
   logic    csr_we = 1'b0;
   logic    csr_wdata = 1'b0;

   logic       table_sel = TABLE_EPA;
   logic [8:0] group_peak = '0;
   rsp_type    expected_indices [$];
   int         mismatch_count = 0;
   int         quiet_cycles = 0;
   int         ready_hold = 0;
   bit         sender_idle = 1'b1;
   bit         receiver_idle = 1'b1;

   air_quality_subindex_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   function automatic rsp_type aqi_of_reading(logic tsel, req_type r, logic [8:0] peak);
      logic [12:0] level;
      logic [12:0] seg_lo;
      logic [12:0] seg_hi;
      int unsigned scaled;
      rsp_type     res;
      bit          found;
      res = '0;
      found = 1'b0;
      level = r.pollutant ? r.concentration : (r.concentration / 13'd10) * 13'd10;
      for (int k = 0; k < SEGMENTS; k++) begin
         seg_lo = BP_LO[tsel][r.pollutant][k];
         seg_hi = BP_HI[tsel][r.pollutant][k];
         if (!found && level >= seg_lo && level <= seg_hi) begin
            scaled = int'(IDX_HI[k] - IDX_LO[k]) * int'(level - seg_lo);
            res.sub_index = IDX_LO[k] + 9'(scaled / int'(seg_hi - seg_lo));
            found = 1'b1;
         end else if (!found && level < seg_lo) begin
            res.sub_index = (k > 0) ? IDX_HI[k-1] : 9'd0;
            found = 1'b1;
         end
      end
      if (!found) begin
         res.sub_index  = INDEX_TOP;
         res.over_range = 1'b1;
      end
      res.overall_index = (res.sub_index > peak) ? res.sub_index : peak;
      res.group_done    = r.last;
      return res;
   endfunction

   function automatic logic [12:0] pick_concentration(logic pol);
      int level;
      level = 0;
      case ($urandom_range(0, 3)) inside
         0: level = $urandom_range(0, 8191);
         1, 2: begin
            if ($urandom_range(0, 1) == 1)
               level = int'(BP_HI[table_sel][pol][$urandom_range(0, SEGMENTS - 1)]);
            else
               level = int'(BP_LO[table_sel][pol][$urandom_range(0, SEGMENTS - 1)]);
            level = level + int'($urandom_range(0, 12)) - 6;
         end
         default: level = $urandom_range(0, 1000);
      endcase
      if (level < 0)
         level = 0;
      if (level > 8191)
         level = 8191;
      return 13'(level);
   endfunction

   task automatic report_mismatch(string what);
      if (mismatch_count < 100)
         $display("mismatch at %0t: %s", $realtime, what);
      mismatch_count++;
   endtask

   task automatic send_reading(logic pol, logic [12:0] conc, logic last);
      req_type    item;
      rsp_type    want;
      int         gap;
      item.pollutant     = pol;
      item.concentration = conc;
      item.last          = last;
      if (sender_idle && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 4);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      want = aqi_of_reading(table_sel, item, group_peak);
      expected_indices = {expected_indices, want};
      group_peak = item.last ? 9'd0 : want.overall_index;
   endtask

   task automatic await_results();
      req_valid <= 1'b0;
      while (expected_indices.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_table(logic sel);
      csr_we    <= 1'b1;
      csr_wdata <= sel;
      @(posedge clock);
      table_sel = sel;
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic test_epa_extremes();
      write_table(TABLE_EPA);
      send_reading(PM10, 13'd0, 1'b0);
      send_reading(PM10, 13'd9, 1'b0);
      send_reading(PM10, 13'd8191, 1'b0);
      send_reading(PM10, 13'd6049, 1'b0);
      send_reading(PM10, 13'd6050, 1'b1);
      send_reading(PM25, 13'd0, 1'b0);
      send_reading(PM25, 13'd120, 1'b0);
      send_reading(PM25, 13'd121, 1'b0);
      send_reading(PM25, 13'd5004, 1'b0);
      send_reading(PM25, 13'd5005, 1'b1);
      send_reading(PM10, 13'd1549, 1'b0);
      send_reading(PM10, 13'd1550, 1'b1);
      await_results();
   endtask

   task automatic test_mep_gaps_and_top();
      write_table(TABLE_MEP);
      send_reading(PM25, 13'd350, 1'b0);
      send_reading(PM25, 13'd351, 1'b0);
      send_reading(PM25, 13'd359, 1'b0);
      send_reading(PM25, 13'd360, 1'b0);
      send_reading(PM25, 13'd5000, 1'b0);
      send_reading(PM25, 13'd5001, 1'b1);
      send_reading(PM10, 13'd509, 1'b0);
      send_reading(PM10, 13'd6000, 1'b0);
      send_reading(PM10, 13'd6010, 1'b1);
      send_reading(PM25, 13'd8191, 1'b1);
      await_results();
   endtask

   task automatic test_random_groups();
      int   group_left;
      logic pol;
      logic last;
      group_left = 0;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: write_table(TABLE_MEP);
            1: write_table(TABLE_EPA);
            default: write_table(logic'($urandom_range(0, 1)));
         endcase
         for (int n = 0; n < PHASE_READINGS; n++) begin
            if (phase == RANDOM_PHASES - 1) begin
               sender_idle   = 1'b0;
               receiver_idle = 1'b0;
            end else if (n % 64 == 0) begin
               sender_idle   = ($urandom_range(0, 3) != 0);
               receiver_idle = ($urandom_range(0, 3) != 0);
            end
            if (group_left == 0)
               group_left = $urandom_range(1, 8);
            last = (group_left == 1);
            if ($urandom_range(0, 9) == 0)
               last = logic'($urandom_range(0, 1));
            group_left--;
            pol = logic'($urandom_range(0, 1));
            send_reading(pol, pick_concentration(pol), last);
         end
         await_results();
      end
   endtask

   always @(posedge clock) begin
      if (ready_hold > 0) begin
         ready_hold <= ready_hold - 1;
      end else if (rsp_ready && receiver_idle && $urandom_range(0, 5) == 0) begin
         rsp_ready  <= 1'b0;
         ready_hold <= $urandom_range(0, 3);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_indices.size() == 0) begin
            report_mismatch($sformatf("result %p with nothing expected", rsp_data));
         end else begin
            want = expected_indices.pop_front();
            if (rsp_data.sub_index !== want.sub_index)
               report_mismatch($sformatf("sub_index %0d, expected %0d",
                                         rsp_data.sub_index, want.sub_index));
            if (rsp_data.overall_index !== want.overall_index)
               report_mismatch($sformatf("overall_index %0d, expected %0d",
                                         rsp_data.overall_index, want.overall_index));
            if (rsp_data.over_range !== want.over_range)
               report_mismatch($sformatf("over_range %0b, expected %0b",
                                         rsp_data.over_range, want.over_range));
            if (rsp_data.group_done !== want.group_done)
               report_mismatch($sformatf("group_done %0b, expected %0b",
                                         rsp_data.group_done, want.group_done));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_epa_extremes();
      test_mep_gaps_and_top();
      test_random_groups();
      await_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// ===== sim.f =====
src/aqs_pkg.sv
src/aqs_mod10.sv
src/aqs_muldiv.sv
src/air_quality_subindex_unit.sv
tb/air_quality_subindex_unit_tb.sv
